### rtl/mavd_pkg.sv
// ----------------------------------------------------------------------------
// mavd_pkg
// Shared constants for the moving average with delta block: window depth
// and the widths that follow from it.
// ----------------------------------------------------------------------------
package mavd_pkg;

    // number of samples held in the ring (1 to 64)
    localparam int WINDOW_SIZE = 4;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + ((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 0);
    localparam int CNT_W    = $clog2(WINDOW_SIZE + 1);
    localparam int PTR_W    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CYC_W    = $clog2(SUM_W);

    // stream widths
    localparam int S_TDATA_W = SAMPLE_W;
    localparam int M_TDATA_W = 2 * SAMPLE_W;

endpackage

### rtl/moving_average_with_delta.sv
// ----------------------------------------------------------------------------
// moving_average_with_delta
// Moving average over the last WINDOW_SIZE samples with the absolute change
// from the previous average, computed one bit per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  s_      | in  | tdata: sample[15:0]                      | s_tvalid/s_tready
//  m_      | out | tdata: average[15:0], change[31:16]; tuser: ready_res
//                                                            | m_tvalid/m_tready
//
//  one sample at a time: a load step, bit-serial sum update over SUM_W bits,
//  radix-2 division by the fill count over SUM_W bits, bit-serial
//  subtraction over 16 bits, then a step into the output register.
//  s_tready is high only while the datapath is idle.
//  a stalled result waits in the output register; the datapath holds in its
//  final state until that register frees up.
//  synchronous active-low reset clears control state and the stored average;
//  ring entries not yet filled are masked by the window-full flag.
// ----------------------------------------------------------------------------
module moving_average_with_delta (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mavd_pkg::S_TDATA_W-1:0]  s_tdata,   // sample[15:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mavd_pkg::M_TDATA_W-1:0]  m_tdata,   // average[15:0], change[31:16]
    output logic                            m_tuser    // ready_res
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_DIFF = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam int SW = mavd_pkg::SAMPLE_W;
    localparam int UW = mavd_pkg::SUM_W;
    localparam int CW = mavd_pkg::CNT_W;
    localparam int PW = mavd_pkg::PTR_W;
    localparam int YW = mavd_pkg::CYC_W;

    state_t          state_reg, state_next;
    logic [SW-1:0]   ring_mem [mavd_pkg::WINDOW_SIZE];
    logic [PW-1:0]   ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic            full_reg;
    logic [YW-1:0]   cnt_reg;
    logic [SW-1:0]   smp_reg;
    logic [SW-1:0]   old_reg;
    logic [UW-1:0]   sum_reg;
    logic [1:0]      carry_reg;
    logic [UW-1:0]   dvd_reg;
    logic [CW-1:0]   rem_reg;
    logic [UW-1:0]   quo_reg;
    logic [SW-1:0]   avg_reg;
    logic [SW-1:0]   prev_reg;
    logic [SW-1:0]   d1_reg, d2_reg;
    logic            b1_reg, b2_reg;
    logic            m_tvalid_reg;
    logic [mavd_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic            m_tuser_reg;

    logic            s_fire;
    logic            out_free;
    logic            cnt_zero;
    logic [2:0]      add_total;
    logic [UW-1:0]   sum_shift;
    logic [CW:0]     trial;
    logic            trial_ge;
    logic [CW:0]     trial_sub;
    logic            a_bit, p_bit;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_zero = (cnt_reg == '0);

    // serial add of sample minus oldest entry, lsb first
    assign add_total = {2'b00, sum_reg[0]} + {2'b00, smp_reg[0]} + {2'b00, ~old_reg[0]}
                     + {1'b0, carry_reg};
    assign sum_shift = {add_total[0], sum_reg[UW-1:1]};

    // one restoring division step per cycle
    assign trial     = {rem_reg, dvd_reg[UW-1]};
    assign trial_ge  = (trial >= {1'b0, fill_reg});
    assign trial_sub = trial - {1'b0, fill_reg};

    // serial subtraction bits
    assign a_bit = avg_reg[0];
    assign p_bit = prev_reg[0];

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_SUM;
            ST_SUM:  if (cnt_zero) state_next = ST_DIV;
            ST_DIV:  if (cnt_zero) state_next = ST_DIFF;
            ST_DIFF: if (cnt_zero) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            full_reg     <= 1'b0;
            sum_reg      <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                ptr_reg  <= (ptr_reg == PW'(mavd_pkg::WINDOW_SIZE - 1)) ? '0 : ptr_reg + 1'b1;
                if (!full_reg) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                full_reg <= full_reg
                         || (fill_reg == CW'(mavd_pkg::WINDOW_SIZE - 1));
            end
            if (state_reg == ST_SUM) begin
                sum_reg <= sum_shift;
            end
            // rotate stored average along with the serial subtract
            if (state_reg == ST_DIFF) begin
                prev_reg <= {p_bit, prev_reg[SW-1:1]};
            end else if (state_reg == ST_DONE && out_free) begin
                prev_reg <= avg_reg;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= full_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ring write and registered read of the oldest entry
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ring_mem[ptr_reg] <= s_tdata;
            old_reg           <= full_reg ? ring_mem[ptr_reg] : '0;
        end else if (state_reg == ST_SUM) begin
            old_reg <= {1'b0, old_reg[SW-1:1]};
        end
    end

    // serial datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                smp_reg   <= s_tdata;
                carry_reg <= 2'b01;
                cnt_reg   <= YW'(UW - 1);
            end
            ST_SUM: begin
                smp_reg   <= {1'b0, smp_reg[SW-1:1]};
                carry_reg <= add_total[2:1];
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_zero) begin
                    dvd_reg <= sum_shift;
                    rem_reg <= '0;
                    cnt_reg <= YW'(UW - 1);
                end
            end
            ST_DIV: begin
                dvd_reg <= {dvd_reg[UW-2:0], 1'b0};
                rem_reg <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
                quo_reg <= {quo_reg[UW-2:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_zero) begin
                    avg_reg <= {quo_reg[SW-2:0], trial_ge};
                    b1_reg  <= 1'b0;
                    b2_reg  <= 1'b0;
                    cnt_reg <= YW'(SW - 1);
                end
            end
            ST_DIFF: begin
                avg_reg <= {a_bit, avg_reg[SW-1:1]};
                d1_reg  <= {a_bit ^ p_bit ^ b1_reg, d1_reg[SW-1:1]};
                d2_reg  <= {a_bit ^ p_bit ^ b2_reg, d2_reg[SW-1:1]};
                b1_reg  <= (~a_bit & p_bit) | (~(a_bit ^ p_bit) & b1_reg);
                b2_reg  <= (~p_bit & a_bit) | (~(a_bit ^ p_bit) & b2_reg);
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {(b1_reg ? d2_reg : d1_reg), avg_reg};
                end
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/mavd_checker.sv
// ----------------------------------------------------------------------------
// mavd_checker
// Port-level checks for the moving average with delta block.
// ----------------------------------------------------------------------------
module mavd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mavd_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mavd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one sample in flight: input closes right after an accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // a result never appears in the cycle after an input beat
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // once the window has filled, the ready flag never drops until reset
    a_ready_sticky: assert property (@(posedge aclk)
        aresetn && $past(aresetn) |-> !$fell(m_tuser))
        else $error("window ready flag dropped");

endmodule

bind moving_average_with_delta mavd_checker u_mavd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
